[rtl/core/s256_pkg.sv]
package s256_pkg;

	localparam int unsigned BlockBytes  = 64;
	localparam int unsigned BlockBits   = BlockBytes * 8;
	localparam int unsigned Rounds      = 64;
	localparam int unsigned DigestWords = 8;

	localparam logic        OP_ABSORB = 1'b0;
	localparam logic        OP_FINISH = 1'b1;

	localparam logic [7:0]  PAD_LEAD   = 8'h80;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  LAST_POS   = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;
	localparam logic [2:0]  LAST_WORD  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} s256_state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} s256_work_t;

	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w9;
		logic [31:0] w14;
	} s256_taps_t;

	localparam logic [31:0] IV_TAB [DigestWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

[rtl/core/s256_in_if.sv]
interface s256_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

[rtl/core/s256_out_if.sv]
interface s256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

[rtl/core/s256_round.sv]
module s256_round import s256_pkg::*; (
	input  s256_work_t  cur,
	input  s256_taps_t  taps,
	input  logic [31:0] k,
	output s256_work_t  nxt,
	output logic [31:0] w_new
);

	function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] s1, ch, t1, s0, maj, t2, g0, g1;

	always_comb begin
		s1  = ror(cur.e, 6) ^ ror(cur.e, 11) ^ ror(cur.e, 25);
		ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
		t1  = cur.h + s1 + ch + k + taps.w0;
		s0  = ror(cur.a, 2) ^ ror(cur.a, 13) ^ ror(cur.a, 22);
		maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
		t2  = s0 + maj;

		nxt.a = t1 + t2;
		nxt.b = cur.a;
		nxt.c = cur.b;
		nxt.d = cur.c;
		nxt.e = cur.d + t1;
		nxt.f = cur.e;
		nxt.g = cur.f;
		nxt.h = cur.g;

		g0    = ror(taps.w1, 7) ^ ror(taps.w1, 18) ^ (taps.w1 >> 3);
		g1    = ror(taps.w14, 17) ^ ror(taps.w14, 19) ^ (taps.w14 >> 10);
		w_new = taps.w0 + g0 + taps.w9 + g1;
	end

endmodule

[rtl/core/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream, one message byte per input word.
// msg (sink): operation 0 absorbs data_byte, operation 1 closes the message.
// digest (source): eight words, word_index 0..7, last_word on index 7;
// digest_word 0 holds the first four digest bytes, most significant first.
// The 64th byte of a block starts a compression: 64 rounds through one
// shared round unit (one round a cycle), then an add into the hash words;
// msg.ready stays low until that add is done.
// A finish feeds the padding and length bytes one a cycle from the current
// fill up to the end of the block, compresses, and when 56 or more bytes
// were pending repeats this for a second block.
// The digest words then wait on digest.ready one at a time; msg.ready stays
// low until the eighth word is taken, after which the hash state is back at
// its initial value and a new message may start.
// Reset (arst_n low) returns to the initial hash, an empty buffer and a zero
// length at once; no clearing pass is needed.
module sha256_byte_stream_hasher import s256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	s256_in_if.sink     msg,
	s256_out_if.source  digest
);

	s256_state_t          state_q, state_d;
	logic [5:0]           fill_q;
	logic [63:0]          bits_q;
	logic [BlockBits-1:0] win_q;
	s256_work_t           work_q, work_nxt;
	logic [31:0]          hash_q [DigestWords];
	logic [5:0]           round_q;
	logic                 first_q;
	logic                 len_ok_q;
	logic                 fin_q;
	logic [2:0]           idx_q;

	logic                 load_byte;
	logic                 absorb;
	logic                 len_byte;
	logic [7:0]           byte_d;
	logic                 do_round;
	logic                 do_add;
	logic                 out_done;
	logic [31:0]          w_new;
	s256_taps_t           taps;
	s256_work_t           hash_work;

	assign taps.w0  = win_q[BlockBits-1 -: 32];
	assign taps.w1  = win_q[BlockBits-1-32 -: 32];
	assign taps.w9  = win_q[BlockBits-1-9*32 -: 32];
	assign taps.w14 = win_q[BlockBits-1-14*32 -: 32];

	assign hash_work = '{a: hash_q[0], b: hash_q[1], c: hash_q[2], d: hash_q[3],
		e: hash_q[4], f: hash_q[5], g: hash_q[6], h: hash_q[7]};

	s256_round u_round (
		.cur   (work_q),
		.taps  (taps),
		.k     (K_TAB[round_q]),
		.nxt   (work_nxt),
		.w_new (w_new)
	);

	assign digest.digest_word = hash_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == LAST_WORD);

	always_comb begin
		state_d      = state_q;
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		load_byte    = 1'b0;
		absorb       = 1'b0;
		len_byte     = 1'b0;
		byte_d       = '0;
		do_round     = 1'b0;
		do_add       = 1'b0;
		out_done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					if (msg.operation == OP_FINISH) begin
						state_d = ST_PAD;
					end else begin
						load_byte = 1'b1;
						absorb    = 1'b1;
						byte_d    = msg.data_byte;
						if (fill_q == LAST_POS) begin
							state_d = ST_ROUND;
						end
					end
				end
			end
			ST_PAD: begin
				load_byte = 1'b1;
				if (first_q) begin
					byte_d = PAD_LEAD;
				end else if (len_ok_q && fill_q >= LEN_POS) begin
					len_byte = 1'b1;
					byte_d   = bits_q[63:56];
				end
				if (fill_q == LAST_POS) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				do_round = 1'b1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				do_add = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (len_ok_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				digest.valid = 1'b1;
				if (digest.ready && idx_q == LAST_WORD) begin
					out_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			bits_q   <= '0;
			round_q  <= '0;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
			fin_q    <= 1'b0;
			idx_q    <= '0;
			for (int i = 0; i < DigestWords; i++) begin
				hash_q[i] <= IV_TAB[i];
			end
		end else begin
			if (load_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (absorb) begin
				bits_q <= bits_q + 64'd8;
			end else if (len_byte) begin
				bits_q <= {bits_q[55:0], 8'h00};
			end
			if (state_q == ST_IDLE && msg.valid && msg.operation == OP_FINISH) begin
				fin_q   <= 1'b1;
				first_q <= 1'b1;
			end
			if (state_q == ST_PAD && first_q) begin
				first_q  <= 1'b0;
				len_ok_q <= (fill_q < LEN_POS);
			end
			if (do_round) begin
				round_q <= round_q + 6'd1;
			end
			if (do_add) begin
				if (fin_q) begin
					len_ok_q <= 1'b1;
				end
				hash_q[0] <= hash_q[0] + work_q.a;
				hash_q[1] <= hash_q[1] + work_q.b;
				hash_q[2] <= hash_q[2] + work_q.c;
				hash_q[3] <= hash_q[3] + work_q.d;
				hash_q[4] <= hash_q[4] + work_q.e;
				hash_q[5] <= hash_q[5] + work_q.f;
				hash_q[6] <= hash_q[6] + work_q.g;
				hash_q[7] <= hash_q[7] + work_q.h;
			end
			if (digest.valid && digest.ready) begin
				idx_q <= idx_q + 3'd1;
			end
			if (out_done) begin
				fin_q    <= 1'b0;
				len_ok_q <= 1'b0;
				for (int i = 0; i < DigestWords; i++) begin
					hash_q[i] <= IV_TAB[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_byte) begin
			win_q <= {win_q[BlockBits-9:0], byte_d};
		end else if (do_round) begin
			win_q <= {win_q[BlockBits-33:0], w_new};
		end
		if (load_byte && fill_q == LAST_POS) begin
			work_q <= hash_work;
		end else if (do_round) begin
			work_q <= work_nxt;
		end
	end

	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> !msg.ready)
		else $error("digest offered while input is open");

	a_round_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != '0) |-> (state_q == ST_ROUND))
		else $error("round counter active outside compression");

	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.operation == OP_ABSORB && fill_q == LAST_POS)
		|=> (state_q == ST_ROUND && fill_q == '0))
		else $error("full block did not start compression");

	a_iv_restore: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word)
		|=> (hash_q[0] == IV_TAB[0] && hash_q[7] == IV_TAB[7] && bits_q == '0
			&& fill_q == '0))
		else $error("state not restored after digest");

	a_len_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && fin_q && len_ok_q) |-> (bits_q == '0))
		else $error("length bytes not fully emitted");

endmodule

[tb/tb_sha256_byte_stream_hasher.sv]
module tb_sha256_byte_stream_hasher import s256_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic       operation;
		logic [7:0] data_byte;
	} byte_word_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_entry_t;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic clk;
	logic arst_n;

	s256_in_if  msg_if ();
	s256_out_if digest_if ();

	sha256_byte_stream_hasher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (digest_if)
	);

	byte_word_t    pending_items [$];
	digest_entry_t digest_due [$];
	digest_entry_t want;

	logic [31:0] hash_state [8];
	logic [7:0]  chunk [64];
	int          chunk_fill;
	logic [63:0] bit_len;

	int items_total;
	int items_taken;
	int send_hold;
	int take_hold;
	bit send_quiet;
	bit take_quiet;
	int mismatches;
	int words_checked;
	int messages_done;
	int blocks_done;
	int two_block_pads;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_chunk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {chunk[4*i], chunk[4*i+1], chunk[4*i+2], chunk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int i = 0; i < 64; i++) begin
			s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
			t1 = h + s1 + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
			s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
			t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
		blocks_done++;
	endtask

	task automatic advance_hash(input logic op, input logic [7:0] b);
		int k;
		digest_entry_t ent;
		if (op == OP_ABSORB) begin
			chunk[chunk_fill] = b;
			chunk_fill++;
			bit_len += 64'd8;
			if (chunk_fill == 64) begin
				compress_chunk();
				chunk_fill = 0;
			end
		end else begin
			chunk[chunk_fill] = 8'h80;
			k = chunk_fill + 1;
			if (k > 56) begin
				while (k < 64) chunk[k++] = 8'h00;
				compress_chunk();
				two_block_pads++;
				k = 0;
			end
			while (k < 56) chunk[k++] = 8'h00;
			for (int i = 0; i < 8; i++)
				chunk[56 + i] = bit_len[63 - 8*i -: 8];
			compress_chunk();
			for (int i = 0; i < 8; i++) begin
				ent.digest_word = hash_state[i];
				ent.word_index  = 3'(i);
				ent.last_word   = (i == 7);
				digest_due.push_back(ent);
			end
			hash_state = SHA_IV;
			chunk_fill = 0;
			bit_len    = '0;
			messages_done++;
		end
	endtask

	task automatic queue_item(input logic op, input logic [7:0] b);
		byte_word_t it;
		it.operation = op;
		it.data_byte = b;
		pending_items.push_back(it);
	endtask

	task automatic queue_random_message(input int len);
		for (int i = 0; i < len; i++)
			queue_item(OP_ABSORB, 8'($urandom));
		queue_item(OP_FINISH, 8'($urandom));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_if.valid     <= 1'b0;
			msg_if.operation <= OP_ABSORB;
			msg_if.data_byte <= '0;
			send_hold = 0;
			send_quiet = 1'b0;
		end else begin
			if (msg_if.valid && msg_if.ready) begin
				advance_hash(msg_if.operation, msg_if.data_byte);
				if (msg_if.operation == OP_FINISH)
					send_quiet = ($urandom_range(0, 2) == 0);
				pending_items.delete(0);
				items_taken++;
			end
			// hold a word that is waiting on ready
			if (!(msg_if.valid && !msg_if.ready)) begin
				if (send_hold > 0) begin
					send_hold--;
					msg_if.valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					msg_if.valid <= 1'b0;
				end else if (!send_quiet && pending_items.size() > 40 &&
						$urandom_range(0, 5) == 0) begin
					send_hold = $urandom_range(0, 13);
					msg_if.valid <= 1'b0;
				end else begin
					msg_if.valid     <= 1'b1;
					msg_if.operation <= pending_items[0].operation;
					msg_if.data_byte <= pending_items[0].data_byte;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_if.ready <= 1'b0;
			take_hold = 0;
			take_quiet = 1'b0;
		end else begin
			if (digest_if.valid && digest_if.ready) begin
				words_checked++;
				if (digest_due.size() == 0) begin
					$error("unexpected digest word: word_index %0d digest_word %h",
						digest_if.word_index, digest_if.digest_word);
					mismatches++;
				end else begin
					want = digest_due.pop_front();
					if (digest_if.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h",
							want.digest_word, digest_if.digest_word);
						mismatches++;
					end
					if (digest_if.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d",
							want.word_index, digest_if.word_index);
						mismatches++;
					end
					if (digest_if.last_word !== want.last_word) begin
						$error("last_word: expected %0d, got %0d",
							want.last_word, digest_if.last_word);
						mismatches++;
					end
				end
				if (digest_if.last_word)
					take_quiet = ($urandom_range(0, 2) == 0);
			end
			if (take_hold > 0) begin
				take_hold--;
				digest_if.ready <= 1'b0;
			end else if (!take_quiet && pending_items.size() > 40 &&
					$urandom_range(0, 5) == 0) begin
				take_hold = $urandom_range(0, 13);
				digest_if.ready <= 1'b0;
			end else begin
				digest_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int msg_len;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.operation = OP_ABSORB;
		msg_if.data_byte = '0;
		digest_if.ready = 1'b0;
		hash_state = SHA_IV;
		chunk_fill = 0;
		bit_len = '0;
		items_taken = 0;
		mismatches = 0;
		words_checked = 0;
		messages_done = 0;
		blocks_done = 0;
		two_block_pads = 0;

		// empty message, with the ignored byte at both extremes
		queue_item(OP_FINISH, 8'h00);
		queue_item(OP_FINISH, 8'hff);
		queue_item(OP_ABSORB, 8'h61);
		queue_item(OP_ABSORB, 8'h62);
		queue_item(OP_ABSORB, 8'h63);
		queue_item(OP_FINISH, 8'h5a);
		queue_item(OP_ABSORB, 8'h00);
		queue_item(OP_ABSORB, 8'hff);
		queue_item(OP_ABSORB, 8'h55);
		queue_item(OP_ABSORB, 8'haa);
		queue_item(OP_FINISH, 8'hff);
		queue_item(OP_ABSORB, 8'h80);
		queue_item(OP_FINISH, 8'h00);

		// padding spills into a second block, then a full block plus up to two bytes
		queue_random_message($urandom_range(56, 63));
		queue_random_message(64 + $urandom_range(0, 2));
		while (pending_items.size() < 210) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: msg_len = $urandom_range(0, 12);
				6, 7:             msg_len = $urandom_range(13, 54);
				8:                msg_len = $urandom_range(55, 64);
				default:          msg_len = $urandom_range(65, 72);
			endcase
			if (pending_items.size() + msg_len + 1 > 210)
				msg_len = 210 - pending_items.size() - 1;
			queue_random_message(msg_len);
		end
		items_total = pending_items.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < items_total) @(posedge clk);
		while (digest_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);

		$display("%0d words sent over %0d messages, %0d blocks compressed (%0d two-block pads)",
			items_total, messages_done, blocks_done, two_block_pads);
		$display("%0d digest words checked, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0 && digest_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d of %0d words taken, %0d digest words due",
			items_taken, items_total, digest_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
